// ----- hw/rtl/mvt_pkg.sv -----
package mvt_pkg;

    localparam int NUM_LANES = 4;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // identity matrix, 1.0 on the diagonal
    localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // stage load enables shared by all lanes
    typedef struct packed {
        logic load;
        logic adv2;
        logic adv3;
    } mvt_pipe_ctrl_t;

endpackage

// ----- hw/rtl/matrix4x4_vector_transform.sv -----
// 4x4 matrix by 4-vector transform, Q16.16 fixed point.
// Input channel: in_valid/in_ready carry mode, in_x..in_w; one vector per transfer.
// Output channel: out_valid/out_ready carry out_x..out_w and overflow.
// Matrix: eight 64-bit column-major registers written through cfg_we/cfg_index/
// cfg_data, two coefficients per register; write only while the block is empty.
// A result passes the product register, loaded at the input transfer edge, then
// the sum, shift/saturate and output registers in that order.
// Throughput: one vector per cycle while out_ready is high; sixteen multipliers,
// four per lane, one lane per result component.
// Stalls: when out_ready is low the output holds and one more result goes
// to a skid entry; the three pipeline stages then fill and in_ready drops.
// in_ready depends only on registered state, never on out_ready.
// Reset: pipeline and output empty, matrix set to identity.
module matrix4x4_vector_transform
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] in_x,
    input  logic signed [DATA_W-1:0] in_y,
    input  logic signed [DATA_W-1:0] in_z,
    input  logic signed [DATA_W-1:0] in_w,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_z,
    output logic signed [DATA_W-1:0] out_w,
    output logic                     overflow
);

    logic [CFG_W-1:0] cfg_reg [CFG_REGS];

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    logic free1;
    logic free2;
    logic free3;
    logic merge_ready;
    mvt_pipe_ctrl_t ctrl;

    logic signed [COEF_WIDTH-1:0] lane_coef [NUM_LANES][NUM_LANES];
    logic signed [DATA_W-1:0]     vec       [NUM_LANES];
    logic signed [DATA_W-1:0]     lane_res  [NUM_LANES];
    logic [NUM_LANES-1:0]         lane_sat;
    logic signed [DATA_W-1:0]     out_res   [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CFG_REGS; j++)
            begin
                cfg_reg[j] <= CFG_RESET[j];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // stage handshake: a stage loads when it is empty or its contents move on
    assign free3    = !v3_reg || merge_ready;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;

    assign ctrl.load = in_valid && free1;
    assign ctrl.adv2 = v1_reg && free2;
    assign ctrl.adv3 = v2_reg && free3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign vec[0] = in_x;
    assign vec[1] = in_y;
    assign vec[2] = in_z;
    assign vec[3] = in_w;

    // entry r of column c sits in register 2c + r/2, half r%2
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        for (genvar k = 0; k < NUM_LANES; k++)
        begin : g_coef
            assign lane_coef[i][k] = mode
                ? cfg_reg[2*i + k/2][(k%2)*DATA_W +: COEF_WIDTH]
                : cfg_reg[2*k + i/2][(i%2)*DATA_W +: COEF_WIDTH];
        end

        mvt_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .COEF_WIDTH (COEF_WIDTH)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .coef (lane_coef[i]),
            .vec  (vec),
            .res  (lane_res[i]),
            .sat  (lane_sat[i])
        );
    end

    mvt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (v3_reg),
        .lane_ready (merge_ready),
        .lane_res   (lane_res),
        .lane_sat   (lane_sat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res),
        .out_ovf    (overflow)
    );

    assign out_x = out_res[0];
    assign out_y = out_res[1];
    assign out_z = out_res[2];
    assign out_w = out_res[3];

`ifndef SYNTH
    a_load_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> v1_reg)
        else $error("accepted vector missing from first stage");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && !merge_ready)
        else $error("input blocked with room in the pipeline");

    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !merge_ready |=> v3_reg)
        else $error("third stage result dropped while merge stalled");
`endif

endmodule

// ----- hw/rtl/mvt_lane.sv -----
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
)
(
    input  logic                         clk,
    input  mvt_pipe_ctrl_t               ctrl,
    input  logic signed [COEF_WIDTH-1:0] coef [NUM_LANES],
    input  logic signed [DATA_W-1:0]     vec  [NUM_LANES],
    output logic signed [DATA_W-1:0]     res,
    output logic                         sat
);

    localparam int PROD_W = DATA_W + COEF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = (SUM_W - FRAC_BITS > DATA_W) ? SUM_W - FRAC_BITS : DATA_W + 1;

    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     sat_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SH_W-1:0]   shifted;
    logic                     fits;
    logic signed [DATA_W-1:0] res_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                prod_reg[k] <= PROD_W'(coef[k]) * PROD_W'(vec[k]);
            end
        end
        if (ctrl.adv2)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.adv3)
        begin
            res_reg <= res_next;
            sat_reg <= !fits;
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);

    // arithmetic shift floors; the result fits when all bits above bit 31 match it
    assign shifted = SH_W'(sum_reg >>> FRAC_BITS);
    assign fits    = (&shifted[SH_W-1:DATA_W-1]) || !(|shifted[SH_W-1:DATA_W-1]);

    always_comb
    begin
        if (fits)
        begin
            res_next = shifted[DATA_W-1:0];
        end
        else if (sum_reg[SUM_W-1])
        begin
            res_next = SAT_MIN;
        end
        else
        begin
            res_next = SAT_MAX;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ----- hw/rtl/mvt_merge.sv -----
module mvt_merge
    import mvt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     lane_valid,
    output logic                     lane_ready,
    input  logic signed [DATA_W-1:0] lane_res [NUM_LANES],
    input  logic [NUM_LANES-1:0]     lane_sat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_res [NUM_LANES],
    output logic                     out_ovf
);

    logic                     out_valid_reg;
    logic                     skid_valid_reg;
    logic signed [DATA_W-1:0] out_res_reg  [NUM_LANES];
    logic signed [DATA_W-1:0] skid_res_reg [NUM_LANES];
    logic                     out_ovf_reg;
    logic                     skid_ovf_reg;

    logic out_free;
    logic up_fire;
    logic ovf_next;

    assign lane_ready = !skid_valid_reg;
    assign up_fire    = lane_valid && lane_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign ovf_next   = |lane_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || up_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (up_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
                out_ovf_reg <= skid_ovf_reg;
            end
            else if (up_fire)
            begin
                out_res_reg <= lane_res;
                out_ovf_reg <= ovf_next;
            end
        end
        else if (up_fire)
        begin
            skid_res_reg <= lane_res;
            skid_ovf_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_ovf   = out_ovf_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mvt_pkg::*;

    localparam int FRAC_SHIFT   = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int MAX_REPORTS  = 10;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic signed [127:0] ACC_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] ACC_MIN = -128'sh8000_0000;
    localparam logic [31:0]         Q_ONE   = 32'h0001_0000;

    typedef enum logic [2:0] {
        MAT_IDENTITY,
        MAT_ALL_MAX,
        MAT_ALL_MIN,
        MAT_LSB,
        MAT_MIXED
    } matrix_kind_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } vec_in_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic               ovf;
    } vec_out_t;

    typedef struct packed {
        matrix_kind_t kind;
        vec_in_t      vec;
        logic         typed;
        vec_out_t     want;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     mode;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic signed [DATA_W-1:0] in_w;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     overflow;

    matrix4x4_vector_transform DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_w      (in_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .overflow  (overflow)
    );

    logic [CFG_W-1:0] matrix_regs [CFG_REGS];
    vec_out_t         expected_results [$];
    int               fail_count    = 0;
    int               sent_count;
    int               checked_count = 0;
    int               cycle_count   = 0;
    bit               tx_steady;
    bit               rx_steady;

    localparam directed_row_t DIRECTED_ROWS [20] = '{
        // identity after reset: result equals input
        '{MAT_IDENTITY, '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{MAT_IDENTITY, '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{MAT_IDENTITY, '{1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX},
          1'b1, '{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0}},
        '{MAT_IDENTITY, '{1'b1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN},
          1'b1, '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b0}},
        '{MAT_IDENTITY, '{1'b0, SAT_MAX, SAT_MIN, 32'h1, 32'hFFFF_FFFF},
          1'b1, '{SAT_MAX, SAT_MIN, 32'h1, 32'hFFFF_FFFF, 1'b0}},
        '{MAT_IDENTITY, '{1'b1, Q_ONE, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA},
          1'b1, '{Q_ONE, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0}},
        // saturation both ways, and in-range sums
        '{MAT_ALL_MAX, '{1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX},
          1'b1, '{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}},
        '{MAT_ALL_MAX, '{1'b1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN},
          1'b1, '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1}},
        '{MAT_ALL_MAX, '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{MAT_ALL_MAX, '{1'b0, 32'h1, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{MAT_ALL_MIN, '{1'b0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN},
          1'b1, '{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}},
        '{MAT_ALL_MIN, '{1'b1, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX},
          1'b1, '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1}},
        '{MAT_ALL_MIN, '{1'b1, 32'hFFFF_FFFF, 32'h0, Q_ONE, 32'h0},
          1'b0, '0},
        // truncation toward minus infinity
        '{MAT_LSB, '{1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{MAT_LSB, '{1'b1, 32'h1, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{MAT_LSB, '{1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX},
          1'b0, '0},
        // asymmetric matrix tells the two modes apart
        '{MAT_MIXED, '{1'b0, Q_ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000},
          1'b0, '0},
        '{MAT_MIXED, '{1'b1, Q_ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000},
          1'b0, '0},
        '{MAT_MIXED, '{1'b0, 32'hFFFE_8000, 32'h0000_4000, SAT_MAX, SAT_MIN},
          1'b0, '0},
        '{MAT_MIXED, '{1'b1, 32'hFFFE_8000, 32'h0000_4000, SAT_MAX, SAT_MIN},
          1'b0, '0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] coef_at(input int col, input int row);
        logic [CFG_W-1:0] word;
        word = matrix_regs[col * 2 + row / 2];
        return (row % 2) ? word[63:32] : word[31:0];
    endfunction

    function automatic vec_out_t transform_vector(input vec_in_t v);
        logic signed [31:0]  comp [4];
        logic signed [31:0]  lane [4];
        logic signed [31:0]  m;
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        longint              prod;
        vec_out_t            r;
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        comp[3] = v.w;
        r.ovf = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                m = v.mode ? coef_at(i, k) : coef_at(k, i);
                prod = longint'(m) * longint'(comp[k]);
                acc = acc + prod;
            end
            shifted = acc >>> FRAC_SHIFT;
            if (shifted > ACC_MAX)
            begin
                lane[i] = SAT_MAX;
                r.ovf = 1'b1;
            end
            else if (shifted < ACC_MIN)
            begin
                lane[i] = SAT_MIN;
                r.ovf = 1'b1;
            end
            else
                lane[i] = shifted[31:0];
        end
        r.x = lane[0];
        r.y = lane[1];
        r.z = lane[2];
        r.w = lane[3];
        return r;
    endfunction

    // mix of wide random, small fractional, extremes and near-zero values
    function automatic logic [31:0] rand_q16();
        logic [31:0] r;
        case ($urandom_range(0, 9)) inside
            [0:3]:   r = $urandom();
            [4:7]:   r = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            8:       r = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
            default: r = $urandom_range(0, 2) - 1;
        endcase
        return r;
    endfunction

    task automatic load_matrix(input logic [CFG_W-1:0] regs [CFG_REGS]);
        for (int i = 0; i < CFG_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= regs[i];
            @(posedge clk);
            matrix_regs[i] = regs[i];
        end
        cfg_we <= 1'b0;
    endtask

    // hold off the sender until every outstanding result has been checked
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic drive_vector(input vec_in_t v, input logic typed, input vec_out_t want);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= v.mode;
        in_x     <= v.x;
        in_y     <= v.y;
        in_z     <= v.z;
        in_w     <= v.w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(typed ? want : transform_vector(v));
        sent_count++;
    endtask

    task automatic set_directed_matrix(input matrix_kind_t kind);
        logic [CFG_W-1:0] regs [CFG_REGS];
        for (int i = 0; i < CFG_REGS; i++)
        begin
            case (kind)
                MAT_ALL_MAX: regs[i] = {SAT_MAX, SAT_MAX};
                MAT_ALL_MIN: regs[i] = {SAT_MIN, SAT_MIN};
                MAT_LSB:     regs[i] = {32'h1, 32'h1};
                default:     regs[i] = CFG_RESET[i];
            endcase
        end
        if (kind == MAT_MIXED)
        begin
            regs[0] = {32'h0002_0000, Q_ONE};
            regs[1] = {32'h0000_0000, 32'hFFFF_8000};
            regs[2] = {32'hFFFD_0000, 32'h0000_4000};
            regs[3] = {SAT_MAX,       Q_ONE};
            regs[4] = {32'h0000_0000, 32'hFFFF_0000};
            regs[5] = {32'h0001_8000, SAT_MIN};
            regs[6] = {32'h0000_C000, 32'h0002_0000};
            regs[7] = {32'h0000_0001, 32'hFFFE_0000};
        end
        load_matrix(regs);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checker: each output transfer against the oldest expectation
    always @(posedge clk)
    begin
        vec_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Unexpected result %h %h %h %h ovf=%0b",
                             out_x, out_y, out_z, out_w, overflow);
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
                    out_w !== want.w || overflow !== want.ovf)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Mismatch on result %0d: expected %h %h %h %h ovf=%0b, got %h %h %h %h ovf=%0b",
                                 checked_count, want.x, want.y, want.z, want.w, want.ovf,
                                 out_x, out_y, out_z, out_w, overflow);
                end
            end
        end
    end

    // receiver: random stall before each transfer, with stall-free stretches
    initial
    begin
        int stall;
        int taken;
        out_ready = 1'b0;
        rx_steady = 1'b0;
        taken     = 0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            if (taken % 24 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin
        matrix_kind_t     cur_kind;
        logic [CFG_W-1:0] regs [CFG_REGS];
        vec_in_t          v;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = 1'b0;
        in_x          = '0;
        in_y          = '0;
        in_z          = '0;
        in_w          = '0;
        sent_count    = 0;
        tx_steady     = 1'b0;
        for (int i = 0; i < CFG_REGS; i++)
            matrix_regs[i] = CFG_RESET[i];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_kind = MAT_IDENTITY;
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind != cur_kind)
            begin
                settle();
                set_directed_matrix(DIRECTED_ROWS[i].kind);
                cur_kind = DIRECTED_ROWS[i].kind;
            end
            drive_vector(DIRECTED_ROWS[i].vec, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            for (int i = 0; i < CFG_REGS; i++)
            begin
                case (p)
                    2:       regs[i] = '0;
                    5:       regs[i] = '1;
                    6:       regs[i] = {SAT_MAX, SAT_MIN};
                    default: regs[i] = {rand_q16(), rand_q16()};
                endcase
            end
            load_matrix(regs);
            tx_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                v.mode = 1'($urandom_range(0, 1));
                v.x    = rand_q16();
                v.y    = rand_q16();
                v.z    = rand_q16();
                v.w    = rand_q16();
                drive_vector(v, 1'b0, '0);
                // let the pipe run dry once in mid-stream
                if (p == 3 && n == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    while (expected_results.size() != 0)
                        @(posedge clk);
                end
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d vectors (%0d directed) over %0d matrix settings",
                 sent_count, $size(DIRECTED_ROWS), PHASES);
        $display("Checked %0d results, %0d failures, %0d left outstanding",
                 checked_count, fail_count, expected_results.size());
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
